// ----- hdl/mbee_pkg.sv -----
`default_nettype none

package mbee_pkg;

	localparam int WORDS_PER_ROW = 4;
	localparam int TILE_ROWS     = 256;

	localparam int COV_W       = 64;
	localparam int ROW_INDEX_W = 8;
	localparam int WORD_INDEX_W = 2;
	localparam int TOP_BIT     = COV_W - 1;

	localparam int WORD_W = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
	localparam int ROW_W  = $clog2(TILE_ROWS + 2);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_TDATA_W  = ((COV_W + 2 + 7) / 8) * 8;
	localparam int OUT_BITS    = ROW_INDEX_W + WORD_INDEX_W + 4 * COV_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	typedef logic [WORD_W-1:0] word_pos_t;
	typedef logic [ROW_W-1:0]  row_pos_t;
	typedef logic [COV_W-1:0]  cov_t;

	localparam word_pos_t WORD_LAST      = WORD_W'(WORDS_PER_ROW - 1);
	localparam row_pos_t  ROW_LAST       = ROW_W'(TILE_ROWS + 1);
	localparam row_pos_t  ROW_FIRST_TILE = ROW_W'(2);

	typedef struct packed {
		logic [ROW_INDEX_W-1:0]  row_index;
		logic [WORD_INDEX_W-1:0] word_index;
		cov_t                    cur;
		cov_t                    upper;
		cov_t                    lower;
		logic                    side_left;
		logic                    side_right;
		logic                    last;
	} entry_t;

	typedef struct packed {
		logic [ROW_INDEX_W-1:0]  row_index;
		logic [WORD_INDEX_W-1:0] word_index;
		cov_t                    top_edges;
		cov_t                    bottom_edges;
		cov_t                    left_edges;
		cov_t                    right_edges;
		logic                    tile_done;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ----- hdl/mbee_front.sv -----
`default_nettype none

module mbee_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            coverage_word,
	input  logic                   left_pixel,
	input  logic                   right_pixel,
	input  logic                   tile_start,
	input  mbee_pkg::queue_status_t q_status,
	output logic                   push,
	output mbee_pkg::entry_t       push_entry
);
	import mbee_pkg::*;

	word_pos_t word_q, w_cur, word_nxt;
	row_pos_t  row_q, r_cur, row_nxt;
	cov_t      prev_row_q  [WORDS_PER_ROW];
	cov_t      upper_row_q [WORDS_PER_ROW];
	logic [1:0] side_q     [WORDS_PER_ROW];
	logic      accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		w_cur = tile_start ? '0 : word_q;
		r_cur = tile_start ? '0 : row_q;
		if (w_cur == WORD_LAST) begin
			word_nxt = '0;
			row_nxt  = (r_cur == ROW_LAST) ? '0 : r_cur + row_pos_t'(1);
		end else begin
			word_nxt = w_cur + word_pos_t'(1);
			row_nxt  = r_cur;
		end
	end

	always_comb begin
		push                  = accept && (r_cur >= ROW_FIRST_TILE);
		push_entry.row_index  = ROW_INDEX_W'(r_cur - ROW_FIRST_TILE);
		push_entry.word_index = WORD_INDEX_W'(w_cur);
		push_entry.cur        = prev_row_q[w_cur];
		push_entry.upper      = upper_row_q[w_cur];
		push_entry.lower      = coverage_word;
		push_entry.side_left  = side_q[w_cur][0];
		push_entry.side_right = side_q[w_cur][1];
		push_entry.last       = (r_cur == ROW_LAST) && (w_cur == WORD_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			row_q  <= '0;
			for (int i = 0; i < WORDS_PER_ROW; i++) begin
				prev_row_q[i]  <= '0;
				upper_row_q[i] <= '0;
				side_q[i]      <= '0;
			end
		end else if (accept) begin
			word_q             <= word_nxt;
			row_q              <= row_nxt;
			upper_row_q[w_cur] <= prev_row_q[w_cur];
			prev_row_q[w_cur]  <= coverage_word;
			side_q[w_cur]      <= {right_pixel, left_pixel};
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mbee_queue.sv -----
`default_nettype none

module mbee_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mbee_pkg::entry_t        push_entry,
	input  logic                    pop,
	output mbee_pkg::entry_t        head,
	output mbee_pkg::queue_status_t status
);
	import mbee_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count did not follow push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(count_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- hdl/mbee_back.sv -----
`default_nettype none

module mbee_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  mbee_pkg::entry_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output mbee_pkg::result_t result
);
	import mbee_pkg::*;

	logic    valid_q;
	result_t result_q;
	result_t res_d;

	assign pop       = q_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign result    = result_q;

	always_comb begin
		res_d.row_index    = head.row_index;
		res_d.word_index   = head.word_index;
		res_d.top_edges    = head.cur & ~head.upper;
		res_d.bottom_edges = head.cur & ~head.lower;
		res_d.left_edges   = head.cur & ~{head.cur[TOP_BIT-1:0], head.side_left};
		res_d.right_edges  = head.cur & ~{head.side_right, head.cur[TOP_BIT:1]};
		res_d.tile_done    = head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mask_boundary_edge_extract.sv -----
// Boundary extraction for one tile of a binary coverage mask. Each input transaction
// carries one 64-pixel coverage word plus the single pixels just left and right of it;
// a tile arrives as the seam row above, the tile rows, then the seam row below, each row
// four words. Two line buffers hold the earlier rows, so every tile word comes out one
// row after it went in, as four masks of covered pixels whose upper, lower, left or right
// neighbour is uncovered; the first two rows of the stream give no output. The block
// takes one transaction per clock while the queue is not full: the line buffers are read
// and written in the same cycle, and each result is registered first in a four-entry
// queue and then in an output register, so a stalled output holds up the input only
// once the queue is full.
`default_nettype none

module mask_boundary_edge_extract (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// coverage_word[63:0], left_pixel[64], right_pixel[65], zero fill
	input  logic [mbee_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tile_start
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// row_index[7:0], word_index[9:8], top_edges[73:10], bottom_edges[137:74],
	// left_edges[201:138], right_edges[265:202], zero fill
	output logic [mbee_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// tile_done
	output logic                             m_axis_tlast
);
	import mbee_pkg::*;

	entry_t        push_entry, head;
	queue_status_t q_status;
	logic          push, pop;
	result_t       result;

	mbee_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.coverage_word (s_axis_tdata[COV_W-1:0]),
		.left_pixel    (s_axis_tdata[COV_W]),
		.right_pixel   (s_axis_tdata[COV_W+1]),
		.tile_start    (s_axis_tuser),
		.q_status      (q_status),
		.push          (push),
		.push_entry    (push_entry)
	);

	mbee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	mbee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_status.empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.right_edges, result.left_edges,
		result.bottom_edges, result.top_edges, result.word_index, result.row_index};
	assign m_axis_tlast = result.tile_done;

endmodule

`default_nettype wire

// ----- sim/mbee_edge_checker.sv -----
`timescale 1ns / 1ps

module mbee_edge_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// coverage_word[63:0], left_pixel[64], right_pixel[65], zero fill
	input  logic [mbee_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tile_start
	input  logic                             s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// row_index, word_index, top_edges, bottom_edges, left_edges, right_edges, zero fill
	input  logic [mbee_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// tile_done
	input  logic                             m_axis_tlast,
	output int                               mismatches,
	output int                               outstanding
);
	import mbee_pkg::*;

	localparam int WIDX_LO  = ROW_INDEX_W;
	localparam int TOP_LO   = WIDX_LO + WORD_INDEX_W;
	localparam int BOT_LO   = TOP_LO + COV_W;
	localparam int LEFT_LO  = BOT_LO + COV_W;
	localparam int RIGHT_LO = LEFT_LO + COV_W;

	cov_t       line_prev [WORDS_PER_ROW];
	cov_t       line_prev2 [WORDS_PER_ROW];
	logic [1:0] side_prev [WORDS_PER_ROW];
	int         word_at;
	int         row_at;
	result_t    expected_edges [$];

	task automatic predict_edges(input cov_t cov, input logic lpix, input logic rpix,
			input logic start);
		int      w;
		cov_t    cur;
		result_t r;
		if (start) begin
			word_at = 0;
			row_at  = 0;
		end
		if (word_at >= WORDS_PER_ROW)
			word_at = 0;
		if (row_at > TILE_ROWS + 1)
			row_at = 0;
		w = word_at;
		if (row_at >= 2) begin
			cur            = line_prev[w];
			r.row_index    = ROW_INDEX_W'(row_at - 2);
			r.word_index   = WORD_INDEX_W'(w);
			r.top_edges    = cur & ~line_prev2[w];
			r.bottom_edges = cur & ~cov;
			r.left_edges   = cur & ~{cur[TOP_BIT-1:0], side_prev[w][0]};
			r.right_edges  = cur & ~{side_prev[w][1], cur[TOP_BIT:1]};
			r.tile_done    = (row_at == TILE_ROWS + 1) && (w == WORDS_PER_ROW - 1);
			expected_edges.insert(expected_edges.size(), r);
		end
		line_prev2[w] = line_prev[w];
		line_prev[w]  = cov;
		side_prev[w]  = {rpix, lpix};
		word_at = w + 1;
		if (word_at >= WORDS_PER_ROW) begin
			word_at = 0;
			row_at++;
			if (row_at > TILE_ROWS + 1)
				row_at = 0;
		end
	endtask

	task automatic check_field(input string name, input logic [COV_W-1:0] want,
			input logic [COV_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			for (int w = 0; w < WORDS_PER_ROW; w++) begin
				line_prev[w]  = '0;
				line_prev2[w] = '0;
				side_prev[w]  = '0;
			end
			word_at = 0;
			row_at  = 0;
			expected_edges.delete();
			mismatches = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_edges.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatches++;
				end else begin
					want = expected_edges.pop_front();
					check_field("row_index", COV_W'(want.row_index),
						COV_W'(m_axis_tdata[WIDX_LO-1:0]));
					check_field("word_index", COV_W'(want.word_index),
						COV_W'(m_axis_tdata[TOP_LO-1:WIDX_LO]));
					check_field("top_edges", want.top_edges, m_axis_tdata[BOT_LO-1:TOP_LO]);
					check_field("bottom_edges", want.bottom_edges,
						m_axis_tdata[LEFT_LO-1:BOT_LO]);
					check_field("left_edges", want.left_edges,
						m_axis_tdata[RIGHT_LO-1:LEFT_LO]);
					check_field("right_edges", want.right_edges,
						m_axis_tdata[RIGHT_LO+COV_W-1:RIGHT_LO]);
					check_field("tile_done", COV_W'(want.tile_done), COV_W'(m_axis_tlast));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_edges(s_axis_tdata[COV_W-1:0], s_axis_tdata[COV_W],
					s_axis_tdata[COV_W+1], s_axis_tuser);
		end
		outstanding = expected_edges.size();
	end

endmodule

// ----- sim/tb_mask_boundary_edge_extract.sv -----
`timescale 1ns / 1ps

module tb_mask_boundary_edge_extract;
	import mbee_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEM_TARGET     = 650;
	localparam int DIR_ITEMS       = 5 * WORDS_PER_ROW;

	localparam cov_t DIR_COV [DIR_ITEMS] = '{
		'1, '1, '1, '1,
		'1, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
		'0, 64'h8000_0000_0000_0001, '1, 64'hF0F0_F0F0_F0F0_F0F0,
		'1, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_FFFF_FFFF_0000,
		'0, '1, 64'h5555_5555_5555_5555, '1
	};
	localparam logic [DIR_ITEMS-1:0] DIR_LEFT  = 20'b0110_1010_0101_1100_1111;
	localparam logic [DIR_ITEMS-1:0] DIR_RIGHT = 20'b1001_0110_1100_0101_1111;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int sent = 0;
	bit hold_req;
	bit burst;

	mask_boundary_edge_extract uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	mbee_edge_checker edge_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_mask_boundary_edge_extract: done, errors");
			$finish;
		end
	end

	function automatic cov_t rand_cov();
		cov_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2: v = v & {$urandom, $urandom} & {$urandom, $urandom};
			3: v = v | {$urandom, $urandom};
			4: v = cov_t'(1) << $urandom_range(TOP_BIT);
			5: v = ~(cov_t'(1) << $urandom_range(TOP_BIT));
			6: v = (~cov_t'(0) << $urandom_range(TOP_BIT))
				& (~cov_t'(0) >> $urandom_range(TOP_BIT));
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_item(input cov_t cov, input logic lpix, input logic rpix,
			input logic start);
		if (!burst && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - COV_W - 2){1'b0}}, rpix, lpix, cov};
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_words(input int n, input logic start);
		for (int i = 0; i < n; i++)
			send_item(rand_cov(), 1'($urandom_range(1)), 1'($urandom_range(1)), start && i == 0);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// receiver side
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (burst)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= 26);
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ITEMS; i++)
			send_item(DIR_COV[i], DIR_LEFT[i], DIR_RIGHT[i], i == 0);
		send_item('1, 1'b1, 1'b0, 1'b0);
		// restart in the middle of a row
		send_item(rand_cov(), 1'b0, 1'b1, 1'b1);
		wait_drained();

		// receiver stalls while the sender keeps offering
		hold_req = 1'b1;
		send_words(WORDS_PER_ROW * 40, 1'b1);
		burst = 1'b1;
		send_words(WORDS_PER_ROW * 20, 1'b0);
		burst = 1'b0;
		send_words(WORDS_PER_ROW * 10, 1'b0);
		wait_drained();

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(9))
				0, 1: send_words($urandom_range(1, 3 * WORDS_PER_ROW), 1'b1);
				2: repeat ($urandom_range(1, 6))
					send_item(rand_cov(), 1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)));
				default: send_words(WORDS_PER_ROW * $urandom_range(2, 8), 1'b1);
			endcase
		end
		wait_drained();
		repeat (20) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_mask_boundary_edge_extract: done, clean");
		else
			$display("tb_mask_boundary_edge_extract: done, errors");
		$finish;
	end

endmodule
